### src/alss_pkg.sv
// ----------------------------------------------------------------------------
// alss_pkg
// types, codes and the microcode table of the sorted key list
// ----------------------------------------------------------------------------
package alss_pkg;

  localparam int PC_W = 5;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SORT   = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CND_NEVER  = 3'd0,
    CND_FULL   = 3'd1,
    CND_BADPOS = 3'd2,
    CND_I_END  = 3'd3,
    CND_J_END  = 3'd4,
    CND_NOT_GT = 3'd5,
    CND_HIT    = 3'd6
  } cond_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_I    = 2'd1,
    RD_J    = 2'd2
  } rd_t;

  typedef enum logic [2:0] {
    WR_NONE    = 3'd0,
    WR_CNT_KEY = 3'd1,
    WR_I_RD    = 3'd2,
    WR_I_B     = 3'd3,
    WR_J_A     = 3'd4
  } wr_t;

  typedef enum logic [1:0] {
    IOP_HOLD = 2'd0,
    IOP_POS  = 2'd1,
    IOP_INC  = 2'd2
  } iop_t;

  typedef enum logic [1:0] {
    JOP_HOLD = 2'd0,
    JOP_I1   = 2'd1,
    JOP_INC  = 2'd2
  } jop_t;

  typedef enum logic [1:0] {
    AOP_HOLD = 2'd0,
    AOP_RD   = 2'd1,
    AOP_B    = 2'd2
  } aop_t;

  typedef enum logic [1:0] {
    COP_HOLD = 2'd0,
    COP_INC  = 2'd1,
    COP_DEC  = 2'd2
  } cop_t;

  typedef struct packed {
    cond_t   cond;
    pc_t     br;
    pc_t     nx;
    rd_t     rd;
    wr_t     wr;
    iop_t    iop;
    jop_t    jop;
    aop_t    aop;
    logic    ld_b;
    cop_t    cop;
    logic    fin;
    status_t st;
    logic    st_hit;
    logic    kout_a;
    logic    fpos_i;
  } uword_t;

  // program labels
  localparam pc_t L_APP_CHK   = 5'd0;
  localparam pc_t L_APP_WR    = 5'd1;
  localparam pc_t L_APP_FULL  = 5'd2;
  localparam pc_t L_REM_CHK   = 5'd3;
  localparam pc_t L_REM_RD    = 5'd4;
  localparam pc_t L_REM_KEEP  = 5'd5;
  localparam pc_t L_REM_LOOP  = 5'd6;
  localparam pc_t L_REM_SHIFT = 5'd7;
  localparam pc_t L_REM_DONE  = 5'd8;
  localparam pc_t L_REM_BAD   = 5'd9;
  localparam pc_t L_SRT_OUTER = 5'd10;
  localparam pc_t L_SRT_KEEPA = 5'd11;
  localparam pc_t L_SRT_INNER = 5'd12;
  localparam pc_t L_SRT_KEEPB = 5'd13;
  localparam pc_t L_SRT_CMP   = 5'd14;
  localparam pc_t L_SRT_SWAPI = 5'd15;
  localparam pc_t L_SRT_SWAPJ = 5'd16;
  localparam pc_t L_SRT_NEXTJ = 5'd17;
  localparam pc_t L_SRT_NEXTI = 5'd18;
  localparam pc_t L_SRT_DONE  = 5'd19;
  localparam pc_t L_SCH_RD    = 5'd20;
  localparam pc_t L_SCH_TEST  = 5'd21;
  localparam pc_t L_SCH_MISS  = 5'd22;
  localparam pc_t L_SCH_END   = 5'd23;

  function automatic pc_t entry_pc(op_t op);
    pc_t p;
    case (op)
      OP_APPEND: p = L_APP_CHK;
      OP_REMOVE: p = L_REM_CHK;
      OP_SORT:   p = L_SRT_OUTER;
      OP_SEARCH: p = L_SCH_RD;
      default:   p = L_APP_CHK;
    endcase
    return p;
  endfunction

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    w = '0;
    case (pc)
      L_APP_CHK: begin
        w.cond = CND_FULL; w.br = L_APP_FULL; w.nx = L_APP_WR;
      end
      L_APP_WR: begin
        w.wr = WR_CNT_KEY; w.cop = COP_INC; w.fin = 1'b1; w.st = ST_OK;
      end
      L_APP_FULL: begin
        w.fin = 1'b1; w.st = ST_FULL;
      end
      L_REM_CHK: begin
        w.cond = CND_BADPOS; w.br = L_REM_BAD; w.nx = L_REM_RD; w.iop = IOP_POS;
      end
      L_REM_RD: begin
        w.nx = L_REM_KEEP; w.rd = RD_I; w.jop = JOP_I1;
      end
      L_REM_KEEP: begin
        w.nx = L_REM_LOOP; w.aop = AOP_RD;
      end
      L_REM_LOOP: begin
        w.cond = CND_J_END; w.br = L_REM_DONE; w.nx = L_REM_SHIFT; w.rd = RD_J;
      end
      L_REM_SHIFT: begin
        w.nx = L_REM_LOOP; w.wr = WR_I_RD; w.iop = IOP_INC; w.jop = JOP_INC;
      end
      L_REM_DONE: begin
        w.cop = COP_DEC; w.fin = 1'b1; w.st = ST_OK; w.kout_a = 1'b1;
      end
      L_REM_BAD: begin
        w.fin = 1'b1; w.st = ST_BADPOS;
      end
      L_SRT_OUTER: begin
        w.cond = CND_I_END; w.br = L_SRT_DONE; w.nx = L_SRT_KEEPA;
        w.rd = RD_I; w.jop = JOP_I1;
      end
      L_SRT_KEEPA: begin
        w.nx = L_SRT_INNER; w.aop = AOP_RD;
      end
      L_SRT_INNER: begin
        w.cond = CND_J_END; w.br = L_SRT_NEXTI; w.nx = L_SRT_KEEPB; w.rd = RD_J;
      end
      L_SRT_KEEPB: begin
        w.nx = L_SRT_CMP; w.ld_b = 1'b1;
      end
      L_SRT_CMP: begin
        w.cond = CND_NOT_GT; w.br = L_SRT_NEXTJ; w.nx = L_SRT_SWAPI;
      end
      L_SRT_SWAPI: begin
        w.nx = L_SRT_SWAPJ; w.wr = WR_I_B;
      end
      L_SRT_SWAPJ: begin
        w.nx = L_SRT_NEXTJ; w.wr = WR_J_A; w.aop = AOP_B;
      end
      L_SRT_NEXTJ: begin
        w.nx = L_SRT_INNER; w.jop = JOP_INC;
      end
      L_SRT_NEXTI: begin
        w.nx = L_SRT_OUTER; w.iop = IOP_INC;
      end
      L_SRT_DONE: begin
        w.fin = 1'b1; w.st = ST_OK;
      end
      L_SCH_RD: begin
        w.cond = CND_I_END; w.br = L_SCH_MISS; w.nx = L_SCH_TEST;
        w.rd = RD_I; w.iop = IOP_INC;
      end
      L_SCH_TEST: begin
        w.cond = CND_HIT; w.br = L_SCH_END; w.nx = L_SCH_RD;
      end
      L_SCH_MISS: begin
        w.fin = 1'b1; w.st = ST_NOTFOUND;
      end
      L_SCH_END: begin
        w.fin = 1'b1; w.st_hit = 1'b1; w.fpos_i = 1'b1;
      end
      default: begin
        w.fin = 1'b1; w.st = ST_OK;
      end
    endcase
    return w;
  endfunction

endpackage

### src/alss_keyram.sv
// ----------------------------------------------------------------------------
// alss_keyram
// key storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module alss_keyram #(
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/array_list_sort_search.sv
// ----------------------------------------------------------------------------
// array_list_sort_search
// fixed-capacity list of signed keys: append, remove, exchange sort, search
// ----------------------------------------------------------------------------
// channel  dir  tdata                                        tuser
// in_      in   key_in[31:0] position_in[36:32]              operation[1:0]
// out_     out  key_out[31:0] found_position[36:32]          status[1:0]
//               entry_count[41:37]
//
// one item at a time, stepped by the microcode sequencer over one ram port
// append writes the key at the end of the list, remove shifts the later keys down
// search reads the keys in order and stops on a hit or a larger key, or at list end
// sort swaps on each compare that finds a larger earlier key, n*(n-1)/2 compares
// reset clears the count and control only, no clearing pass over the keys
// a result held on the output stalls only the final step of the next item
// ----------------------------------------------------------------------------
module array_list_sort_search #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // key_in, position_in
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // key_out, found_position, entry_count
  output logic [1:0]  out_tuser   // status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  alss_pkg::uword_t  uw;
  alss_pkg::pc_t     pc_r, pc_nxt;
  logic              busy_r, busy_nxt;
  logic [31:0]       key_r;
  logic [4:0]        pos_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [31:0]       a_r, a_nxt;
  logic [31:0]       b_r, b_nxt;
  logic [31:0]       rd_data;
  logic              accept, out_hold, go, taken, hit_eq;
  logic [PW-1:0]     pos_ext, cnt_ext, posm1, cnt_nxt_ext;
  logic              re, we;
  logic [AW-1:0]     raddr, waddr;
  logic [31:0]       wdata;

  logic              out_valid_r;
  alss_pkg::status_t out_status_r;
  logic [31:0]       out_key_r;
  logic [4:0]        out_fpos_r;
  logic [4:0]        out_cnt_r;

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign uw        = alss_pkg::ucode(pc_r);
  assign out_hold  = out_valid_r && !out_tready;
  assign go        = busy_r && !(uw.fin && out_hold);

  assign pos_ext = PW'(pos_r);
  assign cnt_ext = PW'(cnt_r);
  assign posm1   = pos_ext - PW'(1);
  assign hit_eq  = (rd_data == key_r);

  always_comb begin
    case (uw.cond)
      alss_pkg::CND_NEVER:  taken = 1'b0;
      alss_pkg::CND_FULL:   taken = (cnt_r == CW'(CAPACITY));
      alss_pkg::CND_BADPOS: taken = (pos_ext == '0) || (pos_ext > cnt_ext);
      alss_pkg::CND_I_END:  taken = (i_r >= cnt_r);
      alss_pkg::CND_J_END:  taken = (j_r >= cnt_r);
      alss_pkg::CND_NOT_GT: taken = !($signed(a_r) > $signed(b_r));
      alss_pkg::CND_HIT:    taken = hit_eq || ($signed(rd_data) > $signed(key_r));
      default:              taken = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (accept) begin
      busy_nxt = 1'b1;
      pc_nxt   = alss_pkg::entry_pc(alss_pkg::op_t'(in_tuser));
    end else if (go) begin
      if (uw.fin) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = taken ? uw.br : uw.nx;
      end
    end
  end

  // datapath registers
  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      i_nxt = '0;
    end else if (go) begin
      case (uw.iop)
        alss_pkg::IOP_POS: i_nxt = posm1[CW-1:0];
        alss_pkg::IOP_INC: i_nxt = i_r + CW'(1);
        default:           i_nxt = i_r;
      endcase
      case (uw.jop)
        alss_pkg::JOP_I1:  j_nxt = i_nxt + CW'(1);
        alss_pkg::JOP_INC: j_nxt = j_r + CW'(1);
        default:           j_nxt = j_r;
      endcase
      case (uw.aop)
        alss_pkg::AOP_RD: a_nxt = rd_data;
        alss_pkg::AOP_B:  a_nxt = b_r;
        default:          a_nxt = a_r;
      endcase
      if (uw.ld_b) begin
        b_nxt = rd_data;
      end
      case (uw.cop)
        alss_pkg::COP_INC: cnt_nxt = cnt_r + CW'(1);
        alss_pkg::COP_DEC: cnt_nxt = cnt_r - CW'(1);
        default:           cnt_nxt = cnt_r;
      endcase
    end
  end

  // ram port selection
  always_comb begin
    re    = go && (uw.rd != alss_pkg::RD_NONE);
    raddr = (uw.rd == alss_pkg::RD_J) ? j_r[AW-1:0] : i_r[AW-1:0];
    we    = go && (uw.wr != alss_pkg::WR_NONE);
    case (uw.wr)
      alss_pkg::WR_CNT_KEY: begin
        waddr = cnt_r[AW-1:0];
        wdata = key_r;
      end
      alss_pkg::WR_I_RD: begin
        waddr = i_r[AW-1:0];
        wdata = rd_data;
      end
      alss_pkg::WR_I_B: begin
        waddr = i_r[AW-1:0];
        wdata = b_r;
      end
      alss_pkg::WR_J_A: begin
        waddr = j_r[AW-1:0];
        wdata = a_r;
      end
      default: begin
        waddr = i_r[AW-1:0];
        wdata = key_r;
      end
    endcase
  end

  alss_keyram #(
    .DEPTH (CAPACITY)
  ) u_keyram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign cnt_nxt_ext = PW'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= alss_pkg::L_APP_CHK;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    if (accept) begin
      key_r <= in_tdata[31:0];
      pos_r <= in_tdata[36:32];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (go && uw.fin) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && uw.fin) begin
      if (uw.st_hit) begin
        out_status_r <= hit_eq ? alss_pkg::ST_OK : alss_pkg::ST_NOTFOUND;
      end else begin
        out_status_r <= uw.st;
      end
      out_key_r  <= uw.kout_a ? a_r : 32'd0;
      out_fpos_r <= (uw.fpos_i && hit_eq) ? 5'(i_r) : 5'd0;
      out_cnt_r  <= cnt_nxt_ext[4:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_cnt_r, out_fpos_r, out_key_r};

endmodule
